[hdl/refcounted_page_allocator_core_defines.svh]
// assertion macros for the allocator checker
`ifndef REFCOUNTED_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RPA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define RPA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rpa_pkg.sv]
// shared types and codes of the page allocator
`timescale 1ns / 1ps

package rpa_pkg;

    // register file layout
    localparam int PADDR_W = 4;
    localparam int DATA_W  = 32;
    localparam logic [1:0] REG_REGION_BASE  = 2'd0;
    localparam logic [1:0] REG_FIRST_USABLE = 2'd1;
    localparam logic [1:0] REG_REGION_TOP   = 2'd2;

    localparam logic [31:0] REGION_BASE_RST  = 32'h8000_0000;
    localparam logic [31:0] FIRST_USABLE_RST = 32'h8000_0000;
    localparam logic [31:0] REGION_TOP_RST   = 32'h8800_0000;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADDREF = 2'd2;
    localparam logic [1:0] OP_SEED  = 2'd3;

    // status codes
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_HELD    = 3'd1;
    localparam logic [2:0] STATUS_NOMEM   = 3'd2;
    localparam logic [2:0] STATUS_BADADDR = 3'd3;
    localparam logic [2:0] STATUS_UNDER   = 3'd4;
    localparam logic [2:0] STATUS_SAT     = 3'd5;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } rpa_state_t;

endpackage

[hdl/refcounted_page_allocator_core.sv]
// page allocator core: free-page stack and reference count memories
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------
//  apb     | in        | psel/penable/pready| paddr, pwdata, prdata
//  in      | in        | in_valid/in_stall  | op, page_addr
//  out     | out       | out_valid/out_stall| result_addr, status, count_after
//
// each word runs as a read cycle on the count and stack memories, then
// an execute cycle that writes both back and loads the output register.
// after reset a clearing pass zeroes the count memory with in_stall high;
// register writes are taken during it.
// a stalled output word holds the execute cycle until the register frees up.
`timescale 1ns / 1ps

module refcounted_page_allocator_core
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int COUNT_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [31:0]        page_addr,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        result_addr,
    output logic [2:0]         status,
    output logic [7:0]         count_after
);

    localparam int IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam logic [31:0] OFS_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(NUM_PAGES - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NUM_PAGES);

    // control state
    rpa_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               out_valid_reg, out_valid_next;

    // configuration registers
    logic [31:0] base_reg, first_reg, top_reg;

    // latched word
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             ok_reg;

    // output word
    logic [31:0] result_addr_reg;
    logic [2:0]  status_reg;
    logic [7:0]  count_after_reg;

    // memories
    logic [IDX_W-1:0]      stack_mem [NUM_PAGES];
    logic [COUNT_BITS-1:0] cnt_mem   [NUM_PAGES];
    logic [IDX_W-1:0]      stack_rdata_reg;
    logic [COUNT_BITS-1:0] cnt_rdata_reg;

    // handshake and sequencer strobes
    logic accept, exec_fire, clr_we;

    // address check on the incoming word
    logic [31:0]      addr_diff, addr_pg;
    logic             in_ok;
    logic [IDX_W-1:0] in_idx;

    // execute results
    logic [31:0]           x_addr;
    logic [2:0]            x_status;
    logic [COUNT_BITS-1:0] x_cnt;
    logic                  x_cnt_we;
    logic [COUNT_BITS-1:0] x_cnt_wd;
    logic [IDX_W-1:0]      x_idx;
    logic                  x_push, x_pop;

    // memory port signals
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_wa;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic                  stack_we;
    logic [IDX_W-1:0]      stack_ra;

    // apb register port
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_REGION_BASE:  prdata = base_reg;
            REG_FIRST_USABLE: prdata = first_reg;
            REG_REGION_TOP:   prdata = top_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= REGION_BASE_RST;
            first_reg <= FIRST_USABLE_RST;
            top_reg   <= REGION_TOP_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_REGION_BASE:  base_reg  <= pwdata;
                REG_FIRST_USABLE: first_reg <= pwdata;
                REG_REGION_TOP:   top_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    // page index and bounds of the incoming address
    assign addr_diff = page_addr - base_reg;
    assign addr_pg   = addr_diff >> PAGE_SHIFT;
    assign in_idx    = addr_pg[IDX_W-1:0];
    assign in_ok     = ((page_addr & OFS_MASK) == 32'd0) && (page_addr >= first_reg) &&
                       (page_addr >= base_reg) && (page_addr < top_reg) &&
                       (addr_pg < 32'(NUM_PAGES));

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == CLR_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        accept    = 1'b0;
        exec_fire = 1'b0;
        clr_we    = 1'b0;
        case (state_reg)
            ST_CLEAR: clr_we = 1'b1;
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            ST_EXEC:  exec_fire = !out_valid_reg || !out_stall;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            idx_reg <= in_idx;
            ok_reg  <= in_ok;
        end
    end

    // execute: modify the read count and stack top
    always_comb
    begin
        x_addr   = '0;
        x_status = STATUS_OK;
        x_cnt    = '0;
        x_cnt_we = 1'b0;
        x_cnt_wd = '0;
        x_idx    = idx_reg;
        x_push   = 1'b0;
        x_pop    = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            x_idx = stack_rdata_reg;
            if (depth_reg == '0)
                x_status = STATUS_NOMEM;
            else
            begin
                x_pop    = 1'b1;
                x_cnt_we = 1'b1;
                x_cnt_wd = COUNT_ONE;
                x_cnt    = COUNT_ONE;
                x_addr   = base_reg + 32'(64'(stack_rdata_reg) << PAGE_SHIFT);
            end
        end
        else if (!ok_reg)
            x_status = STATUS_BADADDR;
        else
        begin
            case (op_reg)
                OP_FREE:
                begin
                    if (cnt_rdata_reg == '0)
                        x_status = STATUS_UNDER;
                    else
                    begin
                        x_cnt_we = 1'b1;
                        x_cnt_wd = cnt_rdata_reg - COUNT_ONE;
                        x_cnt    = x_cnt_wd;
                        if (x_cnt_wd != '0)
                            x_status = STATUS_HELD;
                        else
                            x_push = 1'b1;
                    end
                end
                OP_ADDREF:
                begin
                    if (cnt_rdata_reg == COUNT_MAX)
                    begin
                        x_status = STATUS_SAT;
                        x_cnt    = cnt_rdata_reg;
                    end
                    else
                    begin
                        x_cnt_we = 1'b1;
                        x_cnt_wd = cnt_rdata_reg + COUNT_ONE;
                        x_cnt    = x_cnt_wd;
                    end
                end
                OP_SEED:
                begin
                    x_cnt_we = 1'b1;
                    x_push   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // stack depth
    always_comb
    begin
        depth_next = depth_reg;
        if (exec_fire && x_pop)
            depth_next = depth_reg - DEPTH_W'(1);
        else if (exec_fire && x_push && (depth_reg < DEPTH_FULL))
            depth_next = depth_reg + DEPTH_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    // stack memory: pop read at accept, push write at execute
    assign stack_ra = DEPTH_W'(depth_reg - DEPTH_W'(1)) >= DEPTH_FULL ? '0 :
                      IDX_W'(depth_reg - DEPTH_W'(1));
    assign stack_we = exec_fire && x_push && (depth_reg < DEPTH_FULL);

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[depth_reg[IDX_W-1:0]] <= idx_reg;
        if (accept)
            stack_rdata_reg <= stack_mem[stack_ra];
    end

    // count memory: read at accept, write at execute or clearing pass
    assign cnt_we = clr_we || (exec_fire && x_cnt_we);
    assign cnt_wa = clr_we ? clr_idx_reg : x_idx;
    assign cnt_wd = clr_we ? '0 : x_cnt_wd;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        if (accept)
            cnt_rdata_reg <= cnt_mem[in_idx];
    end

    // output register
    assign out_valid_next = exec_fire ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            result_addr_reg <= x_addr;
            status_reg      <= x_status;
            count_after_reg <= 8'(x_cnt);
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_addr = result_addr_reg;
    assign status      = status_reg;
    assign count_after = count_after_reg;

endmodule

[hdl/rpa_checker.sv]
// port-level checker for the page allocator, bound to the top level
`timescale 1ns / 1ps
`include "refcounted_page_allocator_core_defines.svh"

module rpa_checker
    import rpa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [DATA_W-1:0]  pwdata,
    input logic [DATA_W-1:0]  prdata,
    input logic               pready,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         op,
    input logic [31:0]        page_addr,
    input logic               out_valid,
    input logic               out_stall,
    input logic [31:0]        result_addr,
    input logic [2:0]         status,
    input logic [7:0]         count_after
);

    // a stalled output word stays put
    `RPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_addr) && $stable(status) && $stable(count_after), "stalled output word changed")

    // one word at a time: busy right after an accept
    `RPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken twice in a row")

    // only a successful allocate returns an address
    `RPA_ASSERT_NOW(a_addr_only_alloc, out_valid && (status != STATUS_OK), result_addr == 32'd0, "address on failed word")

    // failed words other than a saturated addref report a zero count
    `RPA_ASSERT_NOW(a_fail_no_count, out_valid && ((status == STATUS_NOMEM) || (status == STATUS_BADADDR) || (status == STATUS_UNDER)), count_after == 8'd0, "count on failed word")

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (.*);
